// ===== rtl/core/iffe_pkg.sv =====
// ----------------------------------------------------------------------------
// iffe_pkg
// Shared request codes, controller states, register indexes and the command
// and status bundles between the flood fill controller and its datapath.
// ----------------------------------------------------------------------------
package iffe_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = 7;
    localparam int COORD_W    = 8;
    localparam int COLOUR_W   = 8;
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     DIM_RESET        = 7'd64;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_FILL  = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_READ_DATA,
        ST_SEED_CHECK,
        ST_POP,
        ST_POP_DATA,
        ST_NBR,
        ST_NBR_LAST,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic accept;      // latch the incoming request
        logic sweep_wr;    // write one pixel of a sweep and advance the counter
        logic sweep_full;  // sweep covers the whole store with zero
        logic px_wr_req;   // write the request colour at the request pixel
        logic set_oob;     // flag the request as outside the image
        logic rd_capture;  // take the read data as the result colour
        logic seed_take;   // take the read data as the fill target
        logic seed_push;   // recolour the seed and push it
        logic pop;         // read the top of the stack and drop it
        logic pop_load;    // load the popped pixel as the current center
        logic nbr_issue;   // probe the next neighbor of the center
        logic nbr_check;   // recolour and push the last probe if it matches
        logic resp_load;   // move the result into the output register
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic oob;
        logic sweep_done_full;
        logic sweep_done_clear;
        logic seed_same;
        logic sp_zero;
        logic dir_last;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/iffe_ctrl.sv =====
// ----------------------------------------------------------------------------
// iffe_ctrl
// Sequencer for the flood fill engine: decodes a request and steps the
// datapath through sweeps, pixel accesses and the stack-driven fill.
// ----------------------------------------------------------------------------
module iffe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  iffe_pkg::t_stat  i_stat,
    output iffe_pkg::t_cmd   o_cmd
);

    iffe_pkg::t_state r_state;
    iffe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iffe_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            iffe_pkg::ST_INIT: begin
                o_cmd.sweep_wr   = 1'b1;
                o_cmd.sweep_full = 1'b1;
                if (i_stat.sweep_done_full) begin
                    n_state = iffe_pkg::ST_IDLE;
                end
            end
            iffe_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = iffe_pkg::ST_DECODE;
                end
            end
            iffe_pkg::ST_DECODE: begin
                // The request pixel is read in this cycle for reads and fills.
                if (i_stat.req == iffe_pkg::REQ_CLEAR) begin
                    n_state = iffe_pkg::ST_CLEAR;
                end else if (i_stat.oob) begin
                    o_cmd.set_oob = 1'b1;
                    n_state       = iffe_pkg::ST_RESP;
                end else begin
                    unique case (i_stat.req)
                        iffe_pkg::REQ_WRITE: begin
                            o_cmd.px_wr_req = 1'b1;
                            n_state         = iffe_pkg::ST_RESP;
                        end
                        iffe_pkg::REQ_READ: n_state = iffe_pkg::ST_READ_DATA;
                        iffe_pkg::REQ_FILL: n_state = iffe_pkg::ST_SEED_CHECK;
                        default:            n_state = iffe_pkg::ST_CLEAR;
                    endcase
                end
            end
            iffe_pkg::ST_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_stat.sweep_done_clear) begin
                    n_state = iffe_pkg::ST_RESP;
                end
            end
            iffe_pkg::ST_READ_DATA: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = iffe_pkg::ST_RESP;
            end
            iffe_pkg::ST_SEED_CHECK: begin
                o_cmd.seed_take = 1'b1;
                if (i_stat.seed_same) begin
                    n_state = iffe_pkg::ST_RESP;
                end else begin
                    o_cmd.seed_push = 1'b1;
                    n_state         = iffe_pkg::ST_POP;
                end
            end
            iffe_pkg::ST_POP: begin
                if (i_stat.sp_zero) begin
                    n_state = iffe_pkg::ST_RESP;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = iffe_pkg::ST_POP_DATA;
                end
            end
            iffe_pkg::ST_POP_DATA: begin
                o_cmd.pop_load = 1'b1;
                n_state        = iffe_pkg::ST_NBR;
            end
            iffe_pkg::ST_NBR: begin
                // Probe one neighbor while the previous probe is checked.
                o_cmd.nbr_issue = 1'b1;
                o_cmd.nbr_check = 1'b1;
                if (i_stat.dir_last) begin
                    n_state = iffe_pkg::ST_NBR_LAST;
                end
            end
            iffe_pkg::ST_NBR_LAST: begin
                o_cmd.nbr_check = 1'b1;
                n_state         = iffe_pkg::ST_POP;
            end
            iffe_pkg::ST_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.resp_load = 1'b1;
                    n_state         = iffe_pkg::ST_IDLE;
                end
            end
            default: n_state = iffe_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/iffe_datapath.sv =====
// ----------------------------------------------------------------------------
// iffe_datapath
// Pixel store, pending stack, configuration registers, request and probe
// registers, sweep counter and the output register of the flood fill engine.
// ----------------------------------------------------------------------------
module iffe_datapath #(
    parameter int MAX_DIM    = 64,
    parameter int PIXEL_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [iffe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [iffe_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic [1:0]                        i_req_type,
    input  logic [iffe_pkg::COORD_W-1:0]      i_x_coord,
    input  logic [iffe_pkg::COORD_W-1:0]      i_y_coord,
    input  logic [iffe_pkg::COLOUR_W-1:0]     i_colour,
    input  logic                              i_m_tready,
    input  iffe_pkg::t_cmd                    i_cmd,
    output iffe_pkg::t_stat                   o_stat,
    output logic                              o_valid,
    output logic [iffe_pkg::COLOUR_W-1:0]     o_read_colour,
    output logic                              o_status
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_DIM);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int OW    = (DW > iffe_pkg::COORD_W) ? DW : iffe_pkg::COORD_W;
    localparam int QW    = (DW > iffe_pkg::CFG_W) ? DW : iffe_pkg::CFG_W;
    localparam int CW    = DW + 1;
    localparam int MW    = XW + DW;
    localparam int PW    = 2 * DW;
    localparam int SW    = 2 * XW;
    localparam int PB    = PIXEL_BITS;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_LEFT,
        DIR_DOWN,
        DIR_UP
    } t_dir;

    function automatic logic [DW-1:0] clamp_dim(input logic [iffe_pkg::CFG_W-1:0] v);
        if (v == '0) begin
            return DW'(1);
        end else if (QW'(v) > QW'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(v);
        end
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x,
                                              input logic [XW-1:0] y,
                                              input logic [DW-1:0] wd);
        logic [MW-1:0] row;
        row = MW'(y) * MW'(wd);
        return AW'(row + MW'(x));
    endfunction

    // Memories
    logic [PB-1:0]           r_pixel [DEPTH];
    logic [SW-1:0]           r_stack [DEPTH];
    logic [PB-1:0]           r_px_rdata;
    logic [SW-1:0]           r_stk_rdata;

    // Configuration and request
    logic [iffe_pkg::CFG_W-1:0]   r_cfg_w;
    logic [iffe_pkg::CFG_W-1:0]   r_cfg_h;
    iffe_pkg::t_req               r_req;
    logic [iffe_pkg::COORD_W-1:0] r_x;
    logic [iffe_pkg::COORD_W-1:0] r_y;
    logic [PB-1:0]                r_colour;
    logic [PB-1:0]                r_target;

    // Fill walk
    logic [AW:0]             r_sp;
    logic [AW-1:0]           r_cnt;
    logic [XW-1:0]           r_cx;
    logic [XW-1:0]           r_cy;
    t_dir                    r_dir;
    logic                    r_prb_v;
    logic [XW-1:0]           r_prb_x;
    logic [XW-1:0]           r_prb_y;
    logic [AW-1:0]           r_prb_addr;

    // Result and output
    logic [iffe_pkg::COLOUR_W-1:0] r_rd;
    logic                          r_st;
    logic                          r_out_valid;
    logic [iffe_pkg::COLOUR_W-1:0] r_out_rd;
    logic                          r_out_st;

    logic [DW-1:0]           w;
    logic [DW-1:0]           h;
    logic [XW-1:0]           req_x;
    logic [XW-1:0]           req_y;
    logic [AW-1:0]           req_addr;
    logic [AW-1:0]           clear_last;
    logic [PW-1:0]           area;
    logic [XW-1:0]           nbr_x;
    logic [XW-1:0]           nbr_y;
    logic                    nbr_v;
    logic [AW-1:0]           nbr_addr;
    logic                    nbr_hit;
    logic                    push;
    logic [SW-1:0]           push_data;
    logic [AW:0]             sp_dec;
    logic                    sweep_done;
    logic                    px_we;
    logic [AW-1:0]           px_waddr;
    logic [PB-1:0]           px_wdata;
    logic [AW-1:0]           px_raddr;

    assign w          = clamp_dim(r_cfg_w);
    assign h          = clamp_dim(r_cfg_h);
    assign req_x      = r_x[XW-1:0];
    assign req_y      = r_y[XW-1:0];
    assign req_addr   = addr_of(req_x, req_y, w);
    assign area       = PW'(w) * PW'(h);
    assign clear_last = AW'(area - PW'(1));
    assign sp_dec     = r_sp - (AW + 1)'(1);

    always_comb begin
        nbr_x = r_cx;
        nbr_y = r_cy;
        nbr_v = 1'b0;
        unique case (r_dir)
            DIR_RIGHT: begin
                nbr_x = r_cx + XW'(1);
                nbr_v = (CW'(r_cx) + CW'(1)) < CW'(w);
            end
            DIR_LEFT: begin
                nbr_x = r_cx - XW'(1);
                nbr_v = (r_cx != '0);
            end
            DIR_DOWN: begin
                nbr_y = r_cy + XW'(1);
                nbr_v = (CW'(r_cy) + CW'(1)) < CW'(h);
            end
            DIR_UP: begin
                nbr_y = r_cy - XW'(1);
                nbr_v = (r_cy != '0);
            end
            default: nbr_v = 1'b0;
        endcase
    end

    assign nbr_addr  = addr_of(nbr_x, nbr_y, w);
    assign nbr_hit   = i_cmd.nbr_check && r_prb_v && (r_px_rdata == r_target);
    assign push      = i_cmd.seed_push || nbr_hit;
    assign push_data = i_cmd.seed_push ? {req_y, req_x} : {r_prb_y, r_prb_x};

    assign sweep_done = i_cmd.sweep_full ? (r_cnt == AW'(DEPTH - 1)) : (r_cnt == clear_last);

    always_comb begin
        px_we    = 1'b0;
        px_waddr = req_addr;
        px_wdata = r_colour;
        priority if (i_cmd.sweep_wr) begin
            px_we    = 1'b1;
            px_waddr = r_cnt;
            px_wdata = i_cmd.sweep_full ? '0 : r_colour;
        end else if (i_cmd.px_wr_req || i_cmd.seed_push) begin
            px_we = 1'b1;
        end else if (nbr_hit) begin
            px_we    = 1'b1;
            px_waddr = r_prb_addr;
        end
    end

    assign px_raddr = i_cmd.nbr_issue ? nbr_addr : req_addr;

    always_ff @(posedge i_clk) begin
        if (px_we) begin
            r_pixel[px_waddr] <= px_wdata;
        end
        r_px_rdata <= r_pixel[px_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[r_sp[AW-1:0]] <= push_data;
        end
        r_stk_rdata <= r_stack[sp_dec[AW-1:0]];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= iffe_pkg::DIM_RESET;
            r_cfg_h     <= iffe_pkg::DIM_RESET;
            r_sp        <= '0;
            r_cnt       <= '0;
            r_dir       <= DIR_RIGHT;
            r_prb_v     <= 1'b0;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    iffe_pkg::CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_wdata;
                    iffe_pkg::CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.sweep_wr) begin
                r_cnt <= sweep_done ? '0 : r_cnt + AW'(1);
            end
            if (push) begin
                r_sp <= r_sp + (AW + 1)'(1);
            end else if (i_cmd.pop) begin
                r_sp <= sp_dec;
            end
            if (i_cmd.seed_take) begin
                r_target <= r_px_rdata;
            end
            if (i_cmd.pop_load) begin
                r_dir   <= DIR_RIGHT;
                r_prb_v <= 1'b0;
            end else if (i_cmd.nbr_issue) begin
                r_dir   <= t_dir'(r_dir + 2'd1);
                r_prb_v <= nbr_v;
            end
            if (i_cmd.resp_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req    <= iffe_pkg::t_req'(i_req_type);
            r_x      <= i_x_coord;
            r_y      <= i_y_coord;
            r_colour <= PB'(i_colour);
            r_rd     <= '0;
            r_st     <= 1'b0;
        end
        if (i_cmd.set_oob) begin
            r_st <= 1'b1;
        end
        if (i_cmd.rd_capture) begin
            r_rd <= iffe_pkg::COLOUR_W'(r_px_rdata);
        end
        if (i_cmd.pop_load) begin
            {r_cy, r_cx} <= r_stk_rdata;
        end
        if (i_cmd.nbr_issue) begin
            r_prb_x    <= nbr_x;
            r_prb_y    <= nbr_y;
            r_prb_addr <= nbr_addr;
        end
        if (i_cmd.resp_load) begin
            r_out_rd <= r_rd;
            r_out_st <= r_st;
        end
    end

    always_comb begin
        o_stat                  = '0;
        o_stat.req              = r_req;
        o_stat.oob              = (OW'(r_x) >= OW'(w)) || (OW'(r_y) >= OW'(h));
        o_stat.sweep_done_full  = (r_cnt == AW'(DEPTH - 1));
        o_stat.sweep_done_clear = (r_cnt == clear_last);
        o_stat.seed_same        = (r_px_rdata == r_colour);
        o_stat.sp_zero          = (r_sp == '0);
        o_stat.dir_last         = (r_dir == DIR_UP);
        o_stat.out_free         = !r_out_valid || i_m_tready;
    end

    assign o_valid       = r_out_valid;
    assign o_read_colour = r_out_rd;
    assign o_status      = r_out_st;

    // Each pixel is pushed at most once, so the stack can never overflow.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_sp < (AW + 1)'(DEPTH)))
        else $error("stack push with the stack full");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_sp != '0))
        else $error("stack pop with the stack empty");

    // A fill only runs when its colour differs from the target.
    a_hit_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nbr_hit |-> (r_colour != r_target))
        else $error("fill recolours with the target colour");

    a_clear_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep_wr && !i_cmd.sweep_full) |-> (r_cnt <= clear_last))
        else $error("clear sweep runs past the image in use");

endmodule

// ===== rtl/core/image_flood_fill_engine_unit.sv =====
// ----------------------------------------------------------------------------
// image_flood_fill_engine_unit
// Image store with clear, pixel write, pixel read and four-connected bucket
// fill from a seed, driven by a request stream with one response each.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Signals                          Contents
//  s (req)   in   i_s_tvalid/o_s_tready/tdata/tuser  one request per transaction
//  m (resp)  out  o_m_tvalid/i_m_tready/o_m_tdata    one response per request
//  cfg       in   i_cfg_we/i_cfg_idx/i_cfg_wdata     image width and height
//
// One request at a time: a write, a read, an out-of-range request, a clear over
// width*height pixels, or a fill that recolors the seed and then probes the
// neighbors of each popped pixel, one neighbor probe per cycle on the
// single pixel store read port. After reset a clearing pass zeroes all
// MAX_DIM*MAX_DIM pixels with o_s_tready low.
// A stalled response waits in the output register while the next request is accepted.
module image_flood_fill_engine_unit #(
    parameter int MAX_DIM    = 64,
    parameter int PIXEL_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [7:0] x_coord, [15:8] y_coord, [23:16] colour
    input  logic [iffe_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // [1:0] req_type
    input  logic [iffe_pkg::S_TUSER_W-1:0]    i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [7:0] read_colour, [8] status, [15:9] zero
    output logic [iffe_pkg::M_TDATA_W-1:0]    o_m_tdata,
    input  logic                              i_cfg_we,
    input  logic [iffe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [iffe_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int PAD_W = iffe_pkg::M_TDATA_W - iffe_pkg::COLOUR_W - 1;

    iffe_pkg::t_cmd                cmd;
    iffe_pkg::t_stat               stat;
    logic [iffe_pkg::COLOUR_W-1:0] read_colour;
    logic                          status;

    iffe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    iffe_datapath #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_s_tuser),
        .i_x_coord     (i_s_tdata[7:0]),
        .i_y_coord     (i_s_tdata[15:8]),
        .i_colour      (i_s_tdata[23:16]),
        .i_m_tready    (i_m_tready),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_m_tvalid),
        .o_read_colour (read_colour),
        .o_status      (status)
    );

    assign o_m_tdata = {{PAD_W{1'b0}}, status, read_colour};

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for image_flood_fill_engine_unit. Requests (clear,
// pixel write, pixel read, bucket fill) are streamed in under random idling
// on both sides. A behavioral image model predicts one response per request,
// and each response is checked in order. Several image sizes are covered,
// including out-of-range register values and a resize that reinterprets
// the stored pixels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IMG_MAX      = 64;
    localparam int STORE_PIXELS = IMG_MAX * IMG_MAX;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        iffe_pkg::t_req kind;
        logic [7:0]     x;
        logic [7:0]     y;
        logic [7:0]     colour;
    } t_pixel_req;

    typedef struct packed {
        logic [7:0] read_colour;
        logic       status;
    } t_pixel_resp;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_s_tvalid  = 1'b0;
    logic                             o_s_tready;
    // [7:0] x_coord, [15:8] y_coord, [23:16] colour
    logic [iffe_pkg::S_TDATA_W-1:0]   i_s_tdata   = '0;
    // [1:0] req_type
    logic [iffe_pkg::S_TUSER_W-1:0]   i_s_tuser   = iffe_pkg::REQ_CLEAR;
    logic                             o_m_tvalid;
    logic                             i_m_tready  = 1'b0;
    // [7:0] read_colour, [8] status, [15:9] zero
    logic [iffe_pkg::M_TDATA_W-1:0]   o_m_tdata;
    logic                             i_cfg_we    = 1'b0;
    logic [iffe_pkg::CFG_IDX_W-1:0]   i_cfg_idx   = iffe_pkg::CFG_IMAGE_WIDTH;
    logic [iffe_pkg::CFG_W-1:0]       i_cfg_wdata = '0;

    image_flood_fill_engine_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Image model and its configuration.
    logic [7:0]  img_model [STORE_PIXELS];
    logic [6:0]  cfg_width;
    logic [6:0]  cfg_height;

    t_pixel_req  pending_reqs[$];
    t_pixel_resp expected_resps[$];
    t_pixel_req  drv_req;
    t_pixel_resp want_resp;
    t_pixel_resp got_resp;

    logic        s_fire = 1'b0;
    int          send_idle_pct = 10;
    int          recv_idle_pct = 51;
    logic        hold_arm  = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          cycle_count = 0;
    int          n_queued = 0;
    int          n_checked = 0;
    int          fail_count = 0;
    int          kind_count [4] = '{0, 0, 0, 0};
    int          outside_count = 0;
    int          size_count = 1;

    function automatic int dim_in_use(input logic [6:0] raw);
        if (raw == 7'd0) return 1;
        if (raw > IMG_MAX) return IMG_MAX;
        return int'(raw);
    endfunction

    // Four-connected fill; a pixel is recolored when pushed, so it is pushed once.
    function automatic void flood_region(input int seed, input int w, input int h,
                                         input logic [7:0] fill);
        int         stack_q[$];
        int         idx;
        int         px;
        int         py;
        int         nb_idx [4];
        logic [3:0] nb_ok;
        logic [7:0] target;
        target = img_model[seed];
        if (target == fill) return;
        img_model[seed] = fill;
        stack_q.push_back(seed);
        while (stack_q.size() > 0) begin
            idx = stack_q.pop_back();
            px = idx % w;
            py = idx / w;
            nb_ok  = {py > 0, py + 1 < h, px > 0, px + 1 < w};
            nb_idx = '{idx + 1, idx - 1, idx + w, idx - w};
            for (int d = 0; d < 4; d++) begin
                if (nb_ok[d] && img_model[nb_idx[d]] == target) begin
                    img_model[nb_idx[d]] = fill;
                    stack_q.push_back(nb_idx[d]);
                end
            end
        end
    endfunction

    function automatic t_pixel_resp image_response(input t_pixel_req req);
        t_pixel_resp resp;
        int          w;
        int          h;
        w = dim_in_use(cfg_width);
        h = dim_in_use(cfg_height);
        resp = '0;
        if (req.kind == iffe_pkg::REQ_CLEAR) begin
            for (int i = 0; i < w * h; i++) img_model[i] = req.colour;
        end else if (req.x >= w || req.y >= h) begin
            resp.status = 1'b1;
        end else if (req.kind == iffe_pkg::REQ_WRITE) begin
            img_model[req.x + req.y * w] = req.colour;
        end else if (req.kind == iffe_pkg::REQ_READ) begin
            resp.read_colour = img_model[req.x + req.y * w];
        end else begin
            flood_region(req.x + req.y * w, w, h, req.colour);
        end
        return resp;
    endfunction

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("image_flood_fill_engine_unit test failed");
            $finish;
        end
    end

    // Request driver: a new item may go out once the previous one was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_fire) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_req = pending_reqs.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {drv_req.colour, drv_req.y, drv_req.x};
                i_s_tuser  <= drv_req.kind;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver stall, started once when armed.
    always @(negedge i_clk) begin
        if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on each accepted request, check each accepted response.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready) begin
                want_resp = image_response(t_pixel_req'({i_s_tuser, i_s_tdata[7:0],
                                                         i_s_tdata[15:8],
                                                         i_s_tdata[23:16]}));
                expected_resps.push_back(want_resp);
                kind_count[i_s_tuser]++;
                if (want_resp.status) outside_count++;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_resps.size() == 0) begin
                    $display("%0t: response %04h with none expected", $time, o_m_tdata);
                    fail_count++;
                end else begin
                    got_resp = expected_resps.pop_front();
                    if (o_m_tdata[7:0] !== got_resp.read_colour) begin
                        $display("%0t: read_colour expected %02h, got %02h", $time,
                                 got_resp.read_colour, o_m_tdata[7:0]);
                        fail_count++;
                    end
                    if (o_m_tdata[8] !== got_resp.status) begin
                        $display("%0t: status expected %0b, got %0b", $time,
                                 got_resp.status, o_m_tdata[8]);
                        fail_count++;
                    end
                    if (o_m_tdata[15:9] !== 7'd0) begin
                        $display("%0t: padding expected 00, got %02h", $time,
                                 o_m_tdata[15:9]);
                        fail_count++;
                    end
                    n_checked++;
                end
            end
        end
    end

    task automatic queue_req(input iffe_pkg::t_req kind, input int x, input int y,
                             input int colour);
        pending_reqs.push_back('{kind, x[7:0], y[7:0], colour[7:0]});
        n_queued++;
    endtask

    task automatic wait_until_drained();
        while (n_checked != n_queued) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [iffe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [iffe_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == iffe_pkg::CFG_IMAGE_WIDTH) cfg_width = val;
        else cfg_height = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_dims(input logic [6:0] w_raw, input logic [6:0] h_raw);
        write_reg(iffe_pkg::CFG_IMAGE_WIDTH, w_raw);
        write_reg(iffe_pkg::CFG_IMAGE_HEIGHT, h_raw);
        size_count++;
    endtask

    // Mostly in-range requests over a small palette so fills meet real regions.
    task automatic run_random_phase(input logic [6:0] w_raw, input logic [6:0] h_raw,
                                    input int n_items);
        int             w;
        int             h;
        int             r;
        int             x;
        int             y;
        int             colour;
        iffe_pkg::t_req kind;
        logic [7:0]     palette [4];
        set_dims(w_raw, h_raw);
        w = dim_in_use(w_raw);
        h = dim_in_use(h_raw);
        palette = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            kind = (r < 8)  ? iffe_pkg::REQ_CLEAR :
                   (r < 48) ? iffe_pkg::REQ_WRITE :
                   (r < 76) ? iffe_pkg::REQ_READ  : iffe_pkg::REQ_FILL;
            x = $urandom_range(w - 1);
            y = $urandom_range(h - 1);
            if ($urandom_range(99) < 15) begin
                if ($urandom_range(1)) x = $urandom_range(255, w);
                else y = $urandom_range(255, h);
            end
            colour = ($urandom_range(99) < 65) ? palette[$urandom_range(3)] : $urandom_range(255);
            queue_req(kind, x, y, colour);
        end
        wait_until_drained();
    endtask

    initial begin
        cfg_width  = iffe_pkg::DIM_RESET;
        cfg_height = iffe_pkg::DIM_RESET;
        for (int i = 0; i < STORE_PIXELS; i++) img_model[i] = 8'h00;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Full image at reset size: corners, outside coordinates, fills.
        queue_req(iffe_pkg::REQ_READ,  0,   0,   8'h00);
        queue_req(iffe_pkg::REQ_WRITE, 63,  63,  8'hFF);
        queue_req(iffe_pkg::REQ_READ,  63,  63,  8'h00);
        queue_req(iffe_pkg::REQ_WRITE, 64,  0,   8'h12);
        queue_req(iffe_pkg::REQ_READ,  0,   64,  8'h00);
        queue_req(iffe_pkg::REQ_FILL,  255, 255, 8'hAA);
        queue_req(iffe_pkg::REQ_FILL,  0,   0,   8'h00);
        queue_req(iffe_pkg::REQ_FILL,  0,   0,   8'h5A);
        queue_req(iffe_pkg::REQ_READ,  62,  63,  8'h00);
        queue_req(iffe_pkg::REQ_READ,  63,  63,  8'h00);
        queue_req(iffe_pkg::REQ_CLEAR, 200, 200, 8'hC3);
        queue_req(iffe_pkg::REQ_READ,  10,  20,  8'h00);
        wait_until_drained();

        // Width 0 acts as one column, height 127 as the full height.
        set_dims(7'd0, 7'd127);
        queue_req(iffe_pkg::REQ_WRITE, 0, 5,  8'h11);
        queue_req(iffe_pkg::REQ_READ,  1, 0,  8'h00);
        queue_req(iffe_pkg::REQ_FILL,  0, 10, 8'h77);
        queue_req(iffe_pkg::REQ_READ,  0, 5,  8'h00);
        queue_req(iffe_pkg::REQ_READ,  0, 63, 8'h00);
        queue_req(iffe_pkg::REQ_READ,  0, 4,  8'h00);
        wait_until_drained();

        // Resize: the same store seen through rows of eight.
        set_dims(7'd8, 7'd8);
        queue_req(iffe_pkg::REQ_READ,  5, 0, 8'h00);
        queue_req(iffe_pkg::REQ_CLEAR, 0, 0, 8'h00);
        queue_req(iffe_pkg::REQ_READ,  7, 7, 8'h00);
        queue_req(iffe_pkg::REQ_FILL,  3, 3, 8'h01);
        queue_req(iffe_pkg::REQ_READ,  0, 0, 8'h00);
        wait_until_drained();

        hold_arm = 1'b1;
        run_random_phase(7'd8, 7'd8, 20);
        run_random_phase(7'd5, 7'd3, 20);

        send_idle_pct = 51;
        recv_idle_pct = 10;
        run_random_phase(7'd1, 7'd1, 18);
        run_random_phase(7'd100, 7'd1, 20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(7'd2, 7'd64, 20);
        run_random_phase(7'd16, 7'd12, 22);
        run_random_phase(7'd64, 7'd64, 10);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_resps.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, expected_resps.size());
            fail_count += expected_resps.size();
        end
        $display("Checked %0d responses: %0d clears, %0d writes, %0d reads, %0d fills,",
                 n_checked, kind_count[iffe_pkg::REQ_CLEAR], kind_count[iffe_pkg::REQ_WRITE],
                 kind_count[iffe_pkg::REQ_READ], kind_count[iffe_pkg::REQ_FILL]);
        $display("%0d of them outside the image, over %0d image sizes; %0d errors.",
                 outside_count, size_count, fail_count);
        if (fail_count == 0) begin
            $display("image_flood_fill_engine_unit test passed");
        end else begin
            $display("image_flood_fill_engine_unit test failed");
        end
        $finish;
    end

endmodule
